>>> hdl/rs_gf256_crc32_encode_check_defines.svh
// Assertion macros used by the checker file of the CRC encoder/checker.
// No dependencies; include by bare file name.
`ifndef RS_GF256_CRC32_ENCODE_CHECK_DEFINES_SVH
`define RS_GF256_CRC32_ENCODE_CHECK_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define RSGC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RSGC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rsgc_pkg.sv
// Types, constants and GF(256) table functions for the CRC encoder/checker.
// No dependencies.
package rsgc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PHASE_ECHO = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

    localparam logic [8:0] GF_POLY  = 9'h11D;
    localparam logic [7:0] GF_K_HI  = 8'h38;
    localparam logic [7:0] GF_K_MID = 8'hCF;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_CHECK_END,
        CMD_ENCODE_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [BYTE_W-1:0] data;
        logic [CRC_W-1:0]  crc;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] aa;
        logic [7:0] acc;
        aa  = {1'b0, a};
        acc = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc = acc ^ aa[7:0];
            aa = {aa[7:0], 1'b0};
            if (aa[8])
                aa = aa ^ GF_POLY;
        end
        return acc;
    endfunction

    function automatic logic [CRC_W-1:0] crc_table(input logic [7:0] i);
        logic [7:0] p;
        logic [7:0] q;
        p = gf_mul(GF_K_HI, i);
        q = gf_mul(GF_K_MID, i);
        return {p, q, p, i};
    endfunction

endpackage

>>> hdl/rsgc_front.sv
// Front end: accepts bytes, updates the CRC register, classifies each item.
// Depends on rsgc_pkg.
module rsgc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rsgc_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last,
    input  logic                       q_full,
    output logic                       push,
    output rsgc_pkg::cmd_t             push_cmd
);

    logic                       mode_reg;
    logic [rsgc_pkg::CRC_W-1:0] crc_reg;
    logic [rsgc_pkg::CRC_W-1:0] crc_next;
    logic [rsgc_pkg::CRC_W-1:0] crc_upd;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign crc_upd = {crc_reg[rsgc_pkg::CRC_W-9:0], 8'h00}
                   ^ rsgc_pkg::crc_table(data_byte ^ crc_reg[rsgc_pkg::CRC_W-1 -: 8]);

    always_comb
    begin
        crc_next = crc_reg;
        if (push)
            crc_next = last ? '0 : crc_upd;
    end

    always_comb
    begin
        push_cmd.data = data_byte;
        push_cmd.crc  = crc_upd;
        if (!last)
            push_cmd.kind = rsgc_pkg::CMD_DATA;
        else if (mode_reg == rsgc_pkg::MODE_CHECK)
            push_cmd.kind = rsgc_pkg::CMD_CHECK_END;
        else
            push_cmd.kind = rsgc_pkg::CMD_ENCODE_END;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rsgc_pkg::MODE_ENCODE;
            crc_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            crc_reg <= crc_next;
        end
    end

endmodule

>>> hdl/rsgc_queue.sv
// Short command queue between the front end and the result sequencer.
// Depends on rsgc_pkg.
module rsgc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rsgc_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output rsgc_pkg::q_head_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rsgc_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/rsgc_back.sv
// Back end: expands each command into its results and drives the output port.
// Depends on rsgc_pkg.
module rsgc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsgc_pkg::q_head_t           head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rsgc_pkg::BYTE_W-1:0] out_byte,
    output logic                        is_crc_byte,
    output logic                        end_of_record,
    output logic                        crc_ok,
    output logic [rsgc_pkg::CRC_W-1:0]  crc_value
);

    rsgc_pkg::cmd_t                cmd_reg, cmd_next;
    logic                          valid_reg, valid_next;
    logic [rsgc_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                          done;
    logic                          advance;
    logic [rsgc_pkg::BYTE_W-1:0]   crc_sel;

    assign done    = (cmd_reg.kind != rsgc_pkg::CMD_ENCODE_END)
                  || (phase_reg == rsgc_pkg::PHASE_LAST);
    assign advance = !valid_reg || (out_ready && done);
    assign pop     = advance && head.valid;

    always_comb
    begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (advance)
        begin
            cmd_next   = head.cmd;
            valid_next = head.valid;
            phase_next = rsgc_pkg::PHASE_ECHO;
        end
        else if (out_ready)
            phase_next = phase_reg + 1'b1;
    end

    always_comb
    begin
        case (phase_reg)
            3'd1:    crc_sel = cmd_reg.crc[31:24];
            3'd2:    crc_sel = cmd_reg.crc[23:16];
            3'd3:    crc_sel = cmd_reg.crc[15:8];
            default: crc_sel = cmd_reg.crc[7:0];
        endcase
    end

    always_comb
    begin
        out_valid     = valid_reg;
        out_byte      = cmd_reg.data;
        is_crc_byte   = 1'b0;
        end_of_record = 1'b0;
        crc_ok        = 1'b0;
        crc_value     = '0;
        unique case (cmd_reg.kind)
            rsgc_pkg::CMD_DATA:
            begin
            end
            rsgc_pkg::CMD_CHECK_END:
            begin
                end_of_record = 1'b1;
                crc_ok        = (cmd_reg.crc == '0);
                crc_value     = cmd_reg.crc;
            end
            rsgc_pkg::CMD_ENCODE_END:
            begin
                if (phase_reg != rsgc_pkg::PHASE_ECHO)
                begin
                    out_byte    = crc_sel;
                    is_crc_byte = 1'b1;
                end
                if (phase_reg == rsgc_pkg::PHASE_LAST)
                begin
                    end_of_record = 1'b1;
                    crc_value     = cmd_reg.crc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= rsgc_pkg::PHASE_ECHO;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

endmodule

>>> hdl/rs_gf256_crc32_encode_check.sv
// Top level of the GF(256) Reed-Solomon CRC-32 record encoder and checker.
// Depends on rsgc_pkg, rsgc_front, rsgc_queue and rsgc_back.
//
// Bytes are accepted one per cycle while the queue is not full and the output
// delivers one result per cycle while out_ready is high. A byte's command is
// written into the queue and then into the back end's command register before
// its result is presented. In encode mode the last byte of a record produces
// five results (the byte, then the four CRC bytes, most significant first),
// and the input keeps accepting until the QUEUE_DEPTH-entry command queue
// fills. The CRC register update is one table lookup and XOR per byte in the
// front end; the back end's result sequencer sets the output rate.
module rs_gf256_crc32_encode_check #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_crc_byte,
    output logic        end_of_record,
    output logic        crc_ok,
    output logic [31:0] crc_value
);

    logic              q_full;
    logic              push;
    logic              pop;
    rsgc_pkg::cmd_t    push_cmd;
    rsgc_pkg::q_head_t head;

    rsgc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    rsgc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    rsgc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_crc_byte   (is_crc_byte),
        .end_of_record (end_of_record),
        .crc_ok        (crc_ok),
        .crc_value     (crc_value)
    );

endmodule

>>> hdl/rsgc_checker.sv
// Port-level checker for the CRC encoder/checker, bound to the top level.
// Depends on rs_gf256_crc32_encode_check_defines.svh.
`include "rs_gf256_crc32_encode_check_defines.svh"

module rsgc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        is_crc_byte,
    input logic        end_of_record,
    input logic        crc_ok,
    input logic [31:0] crc_value
);

    `RSGC_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(crc_value),
        "stalled result changed")
    `RSGC_ASSERT(a_crc_run, clk, rst_n,
        out_valid && out_ready && is_crc_byte && !end_of_record |=> out_valid && is_crc_byte,
        "gap inside CRC byte run")
    `RSGC_ASSERT(a_mid_zero, clk, rst_n,
        out_valid && !end_of_record |-> crc_value == 32'h0 && !crc_ok,
        "status set before record end")
    `RSGC_ASSERT(a_ok_check, clk, rst_n,
        out_valid && crc_ok |-> end_of_record && !is_crc_byte && crc_value == 32'h0,
        "pass flag on wrong result")
    `RSGC_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind rs_gf256_crc32_encode_check rsgc_checker u_rsgc_checker (.*);

>>> dv/tb_rs_gf256_crc32_encode_check.sv
// Testbench for rs_gf256_crc32_encode_check: drives records in encode and check modes,
// predicts every result with its own GF(256) CRC model and checks them in order.
// Depends on rsgc_pkg and the block's RTL.
module tb_rs_gf256_crc32_encode_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 100;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_crc_byte;
        logic        eor;
        logic        ok;
        logic [31:0] value;
    } crc_result_t;

    class crc_scoreboard;
        logic [31:0]  crc_reg;
        logic         mode;
        crc_result_t  expected_q[$];
        int           errors;

        function new();
            crc_reg = '0;
            mode    = rsgc_pkg::MODE_ENCODE;
            errors  = 0;
        endfunction

        static function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            logic [7:0] x;
            acc = '0;
            x   = a;
            for (int k = 0; k < 8; k++)
            begin
                if (b[k])
                    acc = acc ^ x;
                x = {x[6:0], 1'b0} ^ (x[7] ? rsgc_pkg::GF_POLY[7:0] : 8'h00);
            end
            return acc;
        endfunction

        static function logic [31:0] fold_byte(logic [31:0] r, logic [7:0] b);
            logic [7:0] idx;
            logic [7:0] p;
            logic [7:0] q;
            idx = b ^ r[31:24];
            p   = gf_times(rsgc_pkg::GF_K_HI, idx);
            q   = gf_times(rsgc_pkg::GF_K_MID, idx);
            return {r[23:0], 8'h00} ^ {p, q, p, idx};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            crc_reg = fold_byte(crc_reg, b);
            if (!l)
                expected_q.push_back({b, 1'b0, 1'b0, 1'b0, 32'h0});
            else if (mode == rsgc_pkg::MODE_CHECK)
            begin
                expected_q.push_back({b, 1'b0, 1'b1, crc_reg == 32'h0, crc_reg});
                crc_reg = '0;
            end
            else
            begin
                expected_q.push_back({b, 1'b0, 1'b0, 1'b0, 32'h0});
                for (int k = 0; k < 4; k++)
                    expected_q.push_back({crc_reg[31-8*k -: 8], 1'b1, k == 3, 1'b0,
                                          (k == 3) ? crc_reg : 32'h0});
                crc_reg = '0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(crc_result_t act);
            crc_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, act);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("out_byte", 32'(exp_r.out_byte), 32'(act.out_byte));
            compare_field("is_crc_byte", 32'(exp_r.is_crc_byte), 32'(act.is_crc_byte));
            compare_field("end_of_record", 32'(exp_r.eor), 32'(act.eor));
            compare_field("crc_ok", 32'(exp_r.ok), 32'(act.ok));
            compare_field("crc_value", exp_r.value, act.value);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_crc_byte;
    logic        end_of_record;
    logic        crc_ok;
    logic [31:0] crc_value;

    crc_scoreboard sb;
    int  items_sent = 0;
    int  burst_left = 0;
    int  back_to_back_left = 0;
    bit  long_hold_req = 1'b0;
    int  cycle_count = 0;

    rs_gf256_crc32_encode_check dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_crc_byte  (is_crc_byte),
        .end_of_record(end_of_record),
        .crc_ok       (crc_ok),
        .crc_value    (crc_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({out_byte, is_crc_byte, end_of_record, crc_ok, crc_value});
    end

    initial
    begin
        int seg_len;
        int stall_pct;
        @(posedge rst_n);
        forever
        begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 20;
                3: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            for (int i = 0; i < seg_len; i++)
            begin
                @(posedge clk);
                if (long_hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    long_hold_req = 1'b0;
                end
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= l;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_byte(b, l);
        items_sent++;
    endtask

    task automatic offer(input logic [7:0] b, input logic l);
        int gap;
        send_byte(b, l);
        if (back_to_back_left > 0)
            back_to_back_left--;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_mode(input logic m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_record(input logic [7:0] rec[$]);
        foreach (rec[i])
            offer(rec[i], i == rec.size() - 1);
    endtask

    task automatic sealed_record(input logic [7:0] body[$], input bit corrupt);
        logic [7:0]  rec[$];
        logic [31:0] crc;
        int          pos;
        crc = '0;
        rec = body;
        foreach (body[i])
            crc = crc_scoreboard::fold_byte(crc, body[i]);
        for (int k = 0; k < 4; k++)
            rec.push_back(crc[31-8*k -: 8]);
        if (corrupt)
        begin
            pos = $urandom_range(0, rec.size() - 1);
            rec[pos] = rec[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_record(rec);
    endtask

    task automatic random_record(input logic m);
        logic [7:0] body[$];
        int         n;
        int         kind;
        kind = $urandom_range(0, 99);
        if (m == rsgc_pkg::MODE_CHECK && kind < 85)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
        else
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            body.push_back(rand_byte());
        if (m == rsgc_pkg::MODE_CHECK && kind < 85)
            sealed_record(body, kind >= 70);
        else
            send_record(body);
    endtask

    initial
    begin
        logic start_mode;
        logic m;
        int   stop_at;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(rsgc_pkg::MODE_ENCODE);
        send_record('{8'h00, 8'hFF, 8'h80});
        send_record('{8'hFF});
        send_record('{8'h00});

        write_mode(rsgc_pkg::MODE_CHECK);
        sealed_record('{8'h01, 8'hA5}, 1'b0);
        sealed_record('{8'h5A}, 1'b1);
        send_record('{8'h00});
        send_record('{8'hFF});

        offer(8'h12, 1'b0);
        offer(8'h34, 1'b0);
        write_mode(rsgc_pkg::MODE_ENCODE);
        offer(8'h56, 1'b1);
        offer(8'h77, 1'b0);
        write_mode(rsgc_pkg::MODE_CHECK);
        offer(8'h88, 1'b1);

        start_mode = 1'($urandom_range(0, 1));
        for (int phase = 0; phase < 4; phase++)
        begin
            m = start_mode ^ phase[0];
            write_mode(m);
            if (phase == 1)
            begin
                long_hold_req     = 1'b1;
                back_to_back_left = 24;
            end
            stop_at = items_sent + 55;
            while (items_sent < stop_at)
                random_record(m);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
